// ===== rtl/core/cau_pkg.sv =====
package cau_pkg;

	localparam int DW    = 32;  // operand / result part width
	localparam int FB    = 16;  // fraction bits
	localparam int NSTEP = 32;  // quotient and root bits, one per stage

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_MOD = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [DW-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] NEG_MAX = 32'h8000_0000;

	// how the iterative stages treat an item
	typedef enum logic [1:0] {
		K_DIRECT,
		K_DIV,
		K_SQRT
	} kind_t;

	typedef struct packed {
		logic          ovf;
		logic [DW-1:0] val;
	} sat_t;

	// sign-magnitude to saturated two's complement
	function automatic sat_t sat_part(input logic neg, input logic [63:0] mag);
		sat_t r;
		r.ovf = 1'b0;
		r.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
		if (neg && (mag > {32'd0, NEG_MAX})) begin
			r.ovf = 1'b1;
			r.val = NEG_MAX;
		end else if (!neg && (mag > {32'd0, POS_MAX})) begin
			r.ovf = 1'b1;
			r.val = POS_MAX;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/complex_arithmetic_unit_core.sv =====
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide, modulus.
// Pipeline: 5 setup stages, 32 one-bit divide / square-root stages and one output stage
//   lie between the edge that accepts start and done.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset (arst_n low, async): clears all valid bits and zero_threshold; no result
//   strobes until new items flow through.
module complex_arithmetic_unit_core
	import cau_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    func,
	input  logic [DW-1:0] a_re,
	input  logic [DW-1:0] a_im,
	input  logic [DW-1:0] b_re,
	input  logic [DW-1:0] b_im,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	output logic          done,
	output logic [DW-1:0] result_re,
	output logic [DW-1:0] result_im,
	output logic [1:0]    status
);

	// Nothing ever waits: every stage advances each cycle.
	assign busy = 1'b0;

	logic [15:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// ---------------- s1: capture item ----------------
	logic          vld_s1;
	logic [2:0]    func_s1;
	logic [DW-1:0] are_s1, aim_s1, bre_s1, bim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		are_s1  <= a_re;
		aim_s1  <= a_im;
		bre_s1  <= b_re;
		bim_s1  <= b_im;
	end

	// ---------------- s2: products, divisor-zero test ----------------
	logic [32:0] bre_abs, bim_abs;
	assign bre_abs = bre_s1[31] ? (33'd0 - {1'b1, bre_s1}) : {1'b0, bre_s1};
	assign bim_abs = bim_s1[31] ? (33'd0 - {1'b1, bim_s1}) : {1'b0, bim_s1};

	logic              vld_s2;
	logic [2:0]        func_s2;
	logic              dz_s2;
	logic [DW-1:0]     are_s2, aim_s2, bre_s2, bim_s2;
	logic signed [63:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [63:0] p_aa_s2, p_bb_s2, p_cc_s2, p_dd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		dz_s2   <= (bre_abs <= {17'd0, thr_q}) && (bim_abs <= {17'd0, thr_q});
		are_s2  <= are_s1;
		aim_s2  <= aim_s1;
		bre_s2  <= bre_s1;
		bim_s2  <= bim_s1;
		p_rr_s2 <= $signed(are_s1) * $signed(bre_s1);
		p_ii_s2 <= $signed(aim_s1) * $signed(bim_s1);
		p_ri_s2 <= $signed(are_s1) * $signed(bim_s1);
		p_ir_s2 <= $signed(aim_s1) * $signed(bre_s1);
		p_aa_s2 <= $signed(are_s1) * $signed(are_s1);
		p_bb_s2 <= $signed(aim_s1) * $signed(aim_s1);
		p_cc_s2 <= $signed(bre_s1) * $signed(bre_s1);
		p_dd_s2 <= $signed(bim_s1) * $signed(bim_s1);
	end

	// ---------------- s3: sums ----------------
	logic [64:0] re_sum, im_sum;

	always_comb begin
		re_sum = '0;
		im_sum = '0;
		case (func_s2)
			FN_ADD: begin
				re_sum = {{33{are_s2[31]}}, are_s2} + {{33{bre_s2[31]}}, bre_s2};
				im_sum = {{33{aim_s2[31]}}, aim_s2} + {{33{bim_s2[31]}}, bim_s2};
			end
			FN_SUB: begin
				re_sum = {{33{are_s2[31]}}, are_s2} - {{33{bre_s2[31]}}, bre_s2};
				im_sum = {{33{aim_s2[31]}}, aim_s2} - {{33{bim_s2[31]}}, bim_s2};
			end
			FN_MUL: begin
				re_sum = {p_rr_s2[63], p_rr_s2} - {p_ii_s2[63], p_ii_s2};
				im_sum = {p_ri_s2[63], p_ri_s2} + {p_ir_s2[63], p_ir_s2};
			end
			FN_DIV: begin
				// a * conj(b)
				re_sum = {p_rr_s2[63], p_rr_s2} + {p_ii_s2[63], p_ii_s2};
				im_sum = {p_ir_s2[63], p_ir_s2} - {p_ri_s2[63], p_ri_s2};
			end
			default: begin
				re_sum = '0;
				im_sum = '0;
			end
		endcase
	end

	logic        vld_s3;
	logic [2:0]  func_s3;
	logic        dz_s3;
	logic [64:0] re_sum_s3, im_sum_s3;
	logic [63:0] den_s3, sqn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		func_s3   <= func_s2;
		dz_s3     <= dz_s2;
		re_sum_s3 <= re_sum;
		im_sum_s3 <= im_sum;
		// squares are non-negative and each at most 2^62
		den_s3    <= $unsigned(p_cc_s2) + $unsigned(p_dd_s2);
		sqn_s3    <= $unsigned(p_aa_s2) + $unsigned(p_bb_s2);
	end

	// ---------------- s4: to sign-magnitude ----------------
	logic [64:0] re_neg, im_neg;
	assign re_neg = 65'd0 - re_sum_s3;
	assign im_neg = 65'd0 - im_sum_s3;

	logic        vld_s4;
	logic [2:0]  func_s4;
	logic        dz_s4;
	logic        neg_re_s4, neg_im_s4;
	logic [63:0] mag_re_s4, mag_im_s4;
	logic [63:0] den_s4, sqn_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		func_s4   <= func_s3;
		dz_s4     <= dz_s3;
		neg_re_s4 <= re_sum_s3[64];
		neg_im_s4 <= im_sum_s3[64];
		mag_re_s4 <= re_sum_s3[64] ? re_neg[63:0] : re_sum_s3[63:0];
		mag_im_s4 <= im_sum_s3[64] ? im_neg[63:0] : im_sum_s3[63:0];
		den_s4    <= den_s3;
		sqn_s4    <= sqn_s3;
	end

	// ---------------- s5: finish direct ops, seed divider / root ----------------
	// Index 0 of the arrays below is s5; index k is iteration stage k.
	logic              vld_s   [0:NSTEP];
	kind_t             kind_s  [0:NSTEP];
	logic [DW-1:0]     pre_re_s[0:NSTEP];
	logic [DW-1:0]     pre_im_s[0:NSTEP];
	logic [1:0]        pre_st_s[0:NSTEP];
	logic              neg_re_s[0:NSTEP];
	logic              neg_im_s[0:NSTEP];
	logic              ovf_re_s[0:NSTEP];
	logic              ovf_im_s[0:NSTEP];
	logic [63:0]       rem_re_s[0:NSTEP];
	logic [63:0]       rem_im_s[0:NSTEP];
	logic [DW-1:0]     q_re_s  [0:NSTEP];
	logic [DW-1:0]     q_im_s  [0:NSTEP];
	logic [FB-1:0]     lo_re_s [0:NSTEP];
	logic [FB-1:0]     lo_im_s [0:NSTEP];
	logic [63:0]       den_s   [0:NSTEP];
	logic [33:0]       sq_rem_s[0:NSTEP];
	logic [DW-1:0]     sq_rt_s [0:NSTEP];
	logic [63:0]       sq_n_s  [0:NSTEP];

	kind_t       kind_d;
	logic [63:0] dmag_re, dmag_im;
	logic [1:0]  dst_d;
	sat_t        dsat_re, dsat_im;
	logic [63:0] num_re_hi, num_im_hi;

	assign num_re_hi = mag_re_s4 >> FB;
	assign num_im_hi = mag_im_s4 >> FB;

	always_comb begin
		kind_d  = K_DIRECT;
		dmag_re = '0;
		dmag_im = '0;
		dst_d   = ST_OK;
		case (func_s4)
			FN_ADD, FN_SUB: begin
				dmag_re = mag_re_s4;
				dmag_im = mag_im_s4;
			end
			FN_MUL: begin
				dmag_re = num_re_hi;
				dmag_im = num_im_hi;
			end
			FN_DIV: begin
				if (dz_s4) begin
					dst_d = ST_DIV0;
				end else begin
					kind_d = K_DIV;
				end
			end
			FN_MOD: begin
				kind_d = K_SQRT;
			end
			default: begin
				kind_d = K_DIRECT;
			end
		endcase
		dsat_re = sat_part(neg_re_s4, dmag_re);
		dsat_im = sat_part(neg_im_s4, dmag_im);
		if (dsat_re.ovf || dsat_im.ovf) begin
			dst_d = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		kind_s[0]   <= kind_d;
		pre_re_s[0] <= dsat_re.val;
		pre_im_s[0] <= dsat_im.val;
		pre_st_s[0] <= dst_d;
		neg_re_s[0] <= neg_re_s4;
		neg_im_s[0] <= neg_im_s4;
		// quotient of num * 2^16 / den would need more than 32 bits
		ovf_re_s[0] <= num_re_hi >= den_s4;
		ovf_im_s[0] <= num_im_hi >= den_s4;
		rem_re_s[0] <= num_re_hi;
		rem_im_s[0] <= num_im_hi;
		q_re_s[0]   <= '0;
		q_im_s[0]   <= '0;
		lo_re_s[0]  <= mag_re_s4[FB-1:0];
		lo_im_s[0]  <= mag_im_s4[FB-1:0];
		den_s[0]    <= den_s4;
		sq_rem_s[0] <= '0;
		sq_rt_s[0]  <= '0;
		sq_n_s[0]   <= sqn_s4;
	end

	// ---------------- iteration stages: one quotient / root bit each ----------------
	genvar k;
	generate
		for (k = 1; k <= NSTEP; k++) begin : g_it
			logic [64:0] dr_re, dr_im, df_re, df_im;
			logic        ge_re, ge_im;
			logic [35:0] sr, st, sd;
			logic        ge_sq;

			assign dr_re = {rem_re_s[k-1], lo_re_s[k-1][FB-1]};
			assign dr_im = {rem_im_s[k-1], lo_im_s[k-1][FB-1]};
			assign df_re = dr_re - {1'b0, den_s[k-1]};
			assign df_im = dr_im - {1'b0, den_s[k-1]};
			assign ge_re = dr_re >= {1'b0, den_s[k-1]};
			assign ge_im = dr_im >= {1'b0, den_s[k-1]};

			assign sr    = {sq_rem_s[k-1], sq_n_s[k-1][63:62]};
			assign st    = {2'b00, sq_rt_s[k-1], 2'b01};
			assign sd    = sr - st;
			assign ge_sq = sr >= st;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				kind_s[k]   <= kind_s[k-1];
				pre_re_s[k] <= pre_re_s[k-1];
				pre_im_s[k] <= pre_im_s[k-1];
				pre_st_s[k] <= pre_st_s[k-1];
				neg_re_s[k] <= neg_re_s[k-1];
				neg_im_s[k] <= neg_im_s[k-1];
				ovf_re_s[k] <= ovf_re_s[k-1];
				ovf_im_s[k] <= ovf_im_s[k-1];
				rem_re_s[k] <= ge_re ? df_re[63:0] : dr_re[63:0];
				rem_im_s[k] <= ge_im ? df_im[63:0] : dr_im[63:0];
				q_re_s[k]   <= {q_re_s[k-1][DW-2:0], ge_re};
				q_im_s[k]   <= {q_im_s[k-1][DW-2:0], ge_im};
				lo_re_s[k]  <= {lo_re_s[k-1][FB-2:0], 1'b0};
				lo_im_s[k]  <= {lo_im_s[k-1][FB-2:0], 1'b0};
				den_s[k]    <= den_s[k-1];
				sq_rem_s[k] <= ge_sq ? sd[33:0] : sr[33:0];
				sq_rt_s[k]  <= {sq_rt_s[k-1][DW-2:0], ge_sq};
				sq_n_s[k]   <= {sq_n_s[k-1][61:0], 2'b00};
			end
		end
	endgenerate

	// ---------------- output stage ----------------
	sat_t        fs_re, fs_im;
	logic [1:0]  fst;

	always_comb begin
		fs_re = '0;
		fs_im = '0;
		fst   = ST_OK;
		case (kind_s[NSTEP])
			K_DIV: begin
				fs_re = sat_part(neg_re_s[NSTEP],
					ovf_re_s[NSTEP] ? 64'h1_0000_0000 : {32'd0, q_re_s[NSTEP]});
				fs_im = sat_part(neg_im_s[NSTEP],
					ovf_im_s[NSTEP] ? 64'h1_0000_0000 : {32'd0, q_im_s[NSTEP]});
				fst   = (fs_re.ovf || fs_im.ovf) ? ST_SAT : ST_OK;
			end
			K_SQRT: begin
				fs_re = sat_part(1'b0, {32'd0, sq_rt_s[NSTEP]});
				fs_im = '0;
				fst   = fs_re.ovf ? ST_SAT : ST_OK;
			end
			default: begin
				fs_re.val = pre_re_s[NSTEP];
				fs_im.val = pre_im_s[NSTEP];
				fst       = pre_st_s[NSTEP];
			end
		endcase
	end

	logic          done_q;
	logic [DW-1:0] res_re_q, res_im_q;
	logic [1:0]    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		res_re_q <= fs_re.val;
		res_im_q <= fs_im.val;
		status_q <= fst;
	end

	assign done      = done_q;
	assign result_re = res_re_q;
	assign result_im = res_im_q;
	assign status    = status_q;

	// ---------------- checks ----------------
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_DIV0 |-> result_re == '0 && result_im == '0)
		else $error("divide-by-zero item with nonzero result");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SAT |->
			result_re == POS_MAX || result_re == NEG_MAX ||
			result_im == POS_MAX || result_im == NEG_MAX)
		else $error("saturation flagged but no part at a rail");

	a_sqrt_im: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NSTEP] && kind_s[NSTEP] == K_SQRT |=> done && result_im == '0)
		else $error("modulus item with nonzero imaginary part");

endmodule
